>>> sv/ccr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccr_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int PARAM_WIDTH  = 16;
    localparam int COUNT_WIDTH  = 5;
    localparam int INDEX_WIDTH  = 4;
    localparam int STATUS_WIDTH = 2;

    // doubled basis weights stay below 2^(PARAM_WIDTH+4) in magnitude
    localparam int WEIGHT_WIDTH = PARAM_WIDTH + 5;
    localparam int PROD_WIDTH   = WEIGHT_WIDTH + COORD_WIDTH;
    localparam int PAIR_WIDTH   = PROD_WIDTH + 1;
    localparam int SUM_WIDTH    = PROD_WIDTH + 2;
    localparam int RES_WIDTH    = SUM_WIDTH - PARAM_WIDTH - 1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_opcode;

    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_SAT   = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    // element 0 is x, 1 is y, 2 is z
    typedef t_coord [2:0] t_point;

    typedef struct packed {
        t_opcode                  opcode;
        logic [INDEX_WIDTH-1:0]   point_index;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic [PARAM_WIDTH-1:0]   curve_param;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic [STATUS_WIDTH-1:0]  status;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/closed_catmull_rom_point.sv
// Channel   Direction  Handshake                    Payload
// item      in         start, busy                  i_item     (t_in_item)
// result    out        o_strobe                     o_result   (t_out_item)
// config    in         i_cfg_valid, o_cfg_ready     i_cfg_data (point_count)
//
// An item is taken every cycle; busy stays low. An evaluate item gives its
// result through the eight register stages of the datapath (scale,
// index/square, cube/store read, weights, multiply, two adds, round/saturate).
// A write item passes the stage 1 and stage 2 registers and then lands in the
// point store, in item order. Reset clears the count and the stage valid bits;
// the point store is not cleared. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module closed_catmull_rom_point
    import ccr_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire t_in_item               i_item,
    output logic                        o_strobe,
    output t_out_item                   o_result,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [COUNT_WIDTH-1:0] i_cfg_data
);

    localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SCALE_W = PARAM_WIDTH + COUNT_WIDTH;
    localparam int SQ_W    = 2 * PARAM_WIDTH;
    localparam logic signed [WEIGHT_WIDTH-1:0] TWO_ONE = WEIGHT_WIDTH'(2 << PARAM_WIDTH);
    localparam logic signed [SUM_WIDTH-1:0]    RND     = SUM_WIDTH'(1) << PARAM_WIDTH;

    function automatic logic [COUNT_WIDTH-1:0] f_wrap_inc(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [COUNT_WIDTH-1:0] n
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + 1'b1;
        if (s >= {1'b0, n}) begin
            return '0;
        end else begin
            return s[COUNT_WIDTH-1:0];
        end
    endfunction

    // config
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_eff;
    logic                   w_accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;
    assign w_accept    = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    assign n_eff = (int'(r_count) > MAX_POINTS) ? COUNT_WIDTH'(MAX_POINTS) : r_count;

    // stage 1: scale t by n
    logic [SCALE_W-1:0]     w_scaled;
    logic                   r_s1_ev, r_s1_wen, r_s1_empty;
    logic [COUNT_WIDTH-1:0] r_s1_seg, r_s1_n;
    logic [PARAM_WIDTH-1:0] r_s1_u;
    logic [AW-1:0]          r_s1_waddr;
    t_point                 r_s1_wdata;

    assign w_scaled = SCALE_W'(i_item.curve_param) * SCALE_W'(n_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ev  <= 1'b0;
            r_s1_wen <= 1'b0;
        end else begin
            r_s1_ev  <= w_accept && (i_item.opcode == OP_EVAL);
            r_s1_wen <= w_accept && (i_item.opcode == OP_WRITE)
                        && (int'(i_item.point_index) < MAX_POINTS);
        end
        r_s1_empty <= (n_eff == '0);
        r_s1_seg   <= w_scaled[SCALE_W-1:PARAM_WIDTH];
        r_s1_u     <= w_scaled[PARAM_WIDTH-1:0];
        r_s1_n     <= n_eff;
        r_s1_waddr <= AW'(i_item.point_index);
        r_s1_wdata <= {i_item.point_z, i_item.point_y, i_item.point_x};
    end

    // stage 2: neighbor indices, u^2
    logic [COUNT_WIDTH-1:0] w_idx [4];
    logic [SQ_W-1:0]        w_sq;
    logic                   r_s2_ev, r_s2_wen, r_s2_empty;
    logic [AW-1:0]          r_s2_idx [4];
    logic [PARAM_WIDTH-1:0] r_s2_u, r_s2_u2;
    logic [AW-1:0]          r_s2_waddr;
    t_point                 r_s2_wdata;

    always_comb begin
        w_idx[0] = (r_s1_seg == '0) ? (r_s1_n - 1'b1) : (r_s1_seg - 1'b1);
        for (int k = 1; k < 4; k++) begin
            w_idx[k] = f_wrap_inc(w_idx[k-1], r_s1_n);
        end
    end

    assign w_sq = SQ_W'(r_s1_u) * SQ_W'(r_s1_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ev  <= 1'b0;
            r_s2_wen <= 1'b0;
        end else begin
            r_s2_ev  <= r_s1_ev;
            r_s2_wen <= r_s1_wen;
        end
        for (int k = 0; k < 4; k++) begin
            r_s2_idx[k] <= r_s1_empty ? '0 : AW'(w_idx[k]);
        end
        r_s2_empty <= r_s1_empty;
        r_s2_u     <= r_s1_u;
        r_s2_u2    <= w_sq[SQ_W-1:PARAM_WIDTH];
        r_s2_waddr <= r_s1_waddr;
        r_s2_wdata <= r_s1_wdata;
    end

    // stage 3: point store (one copy per read port), u^3
    logic [SQ_W-1:0]        w_cube;
    logic                   r_s3_ev, r_s3_empty;
    logic [PARAM_WIDTH-1:0] r_s3_u, r_s3_u2, r_s3_u3;
    t_point                 r_s3_pt [4];

    for (genvar g = 0; g < 4; g++) begin : g_bank
        t_point r_mem [MAX_POINTS];

        always_ff @(posedge i_clk) begin
            if (r_s2_wen) begin
                r_mem[r_s2_waddr] <= r_s2_wdata;
            end
            r_s3_pt[g] <= r_mem[r_s2_idx[g]];
        end
    end

    assign w_cube = SQ_W'(r_s2_u2) * SQ_W'(r_s2_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ev <= 1'b0;
        end else begin
            r_s3_ev <= r_s2_ev;
        end
        r_s3_empty <= r_s2_empty;
        r_s3_u     <= r_s2_u;
        r_s3_u2    <= r_s2_u2;
        r_s3_u3    <= w_cube[SQ_W-1:PARAM_WIDTH];
    end

    // stage 4: doubled basis weights
    logic signed [WEIGHT_WIDTH-1:0] e1, e2, e3, e3x3, e2x4;
    logic signed [WEIGHT_WIDTH-1:0] w_wt [4];
    logic                           r_s4_ev, r_s4_empty;
    logic signed [WEIGHT_WIDTH-1:0] r_s4_w [4];
    t_point                         r_s4_pt [4];

    always_comb begin
        e1      = $signed(WEIGHT_WIDTH'(r_s3_u));
        e2      = $signed(WEIGHT_WIDTH'(r_s3_u2));
        e3      = $signed(WEIGHT_WIDTH'(r_s3_u3));
        e3x3    = (e3 <<< 1) + e3;
        e2x4    = e2 <<< 2;
        w_wt[0] = (e2 <<< 1) - e3 - e1;
        w_wt[1] = e3x3 - e2x4 - e2 + TWO_ONE;
        w_wt[2] = e2x4 - e3x3 + e1;
        w_wt[3] = e3 - e2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ev <= 1'b0;
        end else begin
            r_s4_ev <= r_s3_ev;
        end
        r_s4_empty <= r_s3_empty;
        r_s4_w     <= w_wt;
        r_s4_pt    <= r_s3_pt;
    end

    // stage 5: weight times coordinate
    logic                         r_s5_ev, r_s5_empty;
    logic signed [PROD_WIDTH-1:0] r_s5_p [3][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_ev <= 1'b0;
        end else begin
            r_s5_ev <= r_s4_ev;
        end
        r_s5_empty <= r_s4_empty;
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
                r_s5_p[c][k] <= r_s4_w[k] * $signed(r_s4_pt[k][c]);
            end
        end
    end

    // stage 6: pair sums
    logic                         r_s6_ev, r_s6_empty;
    logic signed [PAIR_WIDTH-1:0] r_s6_h [3][2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_ev <= 1'b0;
        end else begin
            r_s6_ev <= r_s5_ev;
        end
        r_s6_empty <= r_s5_empty;
        for (int c = 0; c < 3; c++) begin
            r_s6_h[c][0] <= PAIR_WIDTH'(r_s5_p[c][0]) + PAIR_WIDTH'(r_s5_p[c][1]);
            r_s6_h[c][1] <= PAIR_WIDTH'(r_s5_p[c][2]) + PAIR_WIDTH'(r_s5_p[c][3]);
        end
    end

    // stage 7: total, round half up, drop the fraction
    logic signed [SUM_WIDTH-1:0] w_tot [3];
    logic                        r_s7_ev, r_s7_empty;
    logic signed [RES_WIDTH-1:0] r_s7_r [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_tot[c] = SUM_WIDTH'(r_s6_h[c][0]) + SUM_WIDTH'(r_s6_h[c][1]) + RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_ev <= 1'b0;
        end else begin
            r_s7_ev <= r_s6_ev;
        end
        r_s7_empty <= r_s6_empty;
        for (int c = 0; c < 3; c++) begin
            r_s7_r[c] <= w_tot[c][SUM_WIDTH-1:PARAM_WIDTH+1];
        end
    end

    // stage 8: saturate, status
    t_coord          w_sat [3];
    logic [2:0]      w_ovf;
    logic            r_strobe;
    t_out_item       r_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ovf[c] = (r_s7_r[c][RES_WIDTH-1:COORD_WIDTH-1] != '0)
                       && (r_s7_r[c][RES_WIDTH-1:COORD_WIDTH-1] != '1);
            if (!w_ovf[c]) begin
                w_sat[c] = r_s7_r[c][COORD_WIDTH-1:0];
            end else if (r_s7_r[c][RES_WIDTH-1]) begin
                w_sat[c] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end else begin
                w_sat[c] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_s7_ev;
        end
        if (r_s7_empty) begin
            r_out.out_x  <= '0;
            r_out.out_y  <= '0;
            r_out.out_z  <= '0;
            r_out.status <= ST_EMPTY;
        end else begin
            r_out.out_x  <= w_sat[0];
            r_out.out_y  <= w_sat[1];
            r_out.out_z  <= w_sat[2];
            r_out.status <= (w_ovf != '0) ? ST_SAT : ST_OK;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire
